// ===== design/vap_table_with_bssid_mask_macros.svh =====
// ---------------------------------------------------------------------------
// vap table assertion macros
// shared property shapes for the table checker
// ---------------------------------------------------------------------------
`ifndef VAP_TABLE_WITH_BSSID_MASK_MACROS_SVH
`define VAP_TABLE_WITH_BSSID_MASK_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define VTB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define VTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/vtb_pkg.sv =====
// ---------------------------------------------------------------------------
// vtb_pkg
// shared widths, codes and the cell-to-cell link word of the vap table
// ---------------------------------------------------------------------------
package vtb_pkg;

   localparam int ADDR_W            = 48;
   localparam int MAX_ENTRIES_DEF   = 8;
   localparam int MAX_ENTRIES_LIMIT = 64;
   localparam int SLOT_W            = $clog2(MAX_ENTRIES_LIMIT);
   localparam int SLOT_OUT_W        = 3;

   localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

   // request codes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FOUND   = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef enum logic {
      PHASE_SEARCH,
      PHASE_APPLY
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_INSERT,
      ACT_REMOVE
   } action_type;

   // word handed from one cell to the next every cycle
   typedef struct packed {
      logic              active;
      phase_type         phase;
      logic [ADDR_W-1:0] key;
      logic [ADDR_W-1:0] bssid;
      logic              hit;
      logic [SLOT_W-1:0] hit_idx;
      logic [ADDR_W-1:0] hit_bssid;
      logic              free_found;
      logic [SLOT_W-1:0] free_idx;
      action_type        action;
      logic [SLOT_W-1:0] target;
      logic [ADDR_W-1:0] mask;
   } vtb_link_type;

endpackage

// ===== design/vap_table_with_bssid_mask.sv =====
// ---------------------------------------------------------------------------
// vap_table_with_bssid_mask
// table of virtual access points with a running bssid mask
// ---------------------------------------------------------------------------
// usage
//   req channel (valid/ready) carries one request word: op, station address
//   and bssid. rsp channel (valid/ready) returns one word per request with
//   status, slot, stored bssid and the mask after the request.
//   csr_write_enable loads hw_address; write it only while the table is idle.
// sequencing
//   one request at a time. the request walks the row of slot cells once to
//   search; an insert or a remove then walks it a second time to apply the
//   change and rebuild the mask.
// reset
//   all slots invalid, mask all ones, hw_address zero, no response pending.
// stalls
//   the response sits in an output register; a new request is accepted while
//   it waits, and that request's result holds in the done state until the
//   output register frees up.
// ---------------------------------------------------------------------------
module vap_table_with_bssid_mask
   import vtb_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [ADDR_W-1:0]     req_station_address,
   input  logic [ADDR_W-1:0]     req_entry_bssid,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot_index,
   output logic [ADDR_W-1:0]     rsp_stored_bssid,
   output logic [ADDR_W-1:0]     rsp_mask_out,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [ADDR_W-1:0]     csr_write_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_APPLY,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   vtb_link_type             head_ff, head_in;
   vtb_link_type             chain [MAX_ENTRIES];
   vtb_link_type             tail;
   logic [1:0]               op_ff, op_in;
   logic [1:0]               status_ff, status_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [ADDR_W-1:0]        held_ff, held_in;
   logic [ADDR_W-1:0]        mask_ff, mask_in;
   logic [ADDR_W-1:0]        hw_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0]        rsp_bssid_ff, rsp_bssid_in;
   logic [ADDR_W-1:0]        rsp_mask_ff, rsp_mask_in;
   logic                     rebuild;
   action_type               action;
   logic [SLOT_W-1:0]        target;

   // row of slot cells, cell 0 fed by the head register
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_first
         vtb_cell #(.CELL_IDX(g)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .hw_address (hw_ff),
            .left       (head_ff),
            .right      (chain[g])
         );
      end else begin : g_rest
         vtb_cell #(.CELL_IDX(g)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .hw_address (hw_ff),
            .left       (chain[g-1]),
            .right      (chain[g])
         );
      end
   end

   assign tail = chain[MAX_ENTRIES-1];

   // decide the outcome from the search pass at the end of the row
   always_comb begin
      status_in = status_ff;
      slot_in   = slot_ff;
      held_in   = held_ff;
      rebuild   = 1'b0;
      action    = ACT_NONE;
      target    = '0;
      case (op_ff)
         OP_ADD: begin
            if (tail.hit) begin
               status_in = ST_FOUND;
               slot_in   = tail.hit_idx;
               held_in   = tail.hit_bssid;
            end else if (tail.free_found) begin
               status_in = ST_OK;
               slot_in   = tail.free_idx;
               held_in   = tail.bssid;
               rebuild   = 1'b1;
               action    = ACT_INSERT;
               target    = tail.free_idx;
            end else begin
               status_in = ST_FULL;
               slot_in   = '0;
               held_in   = '0;
            end
         end
         OP_REMOVE: begin
            // mask is rebuilt even when nothing is removed
            rebuild = 1'b1;
            if (tail.hit) begin
               status_in = ST_OK;
               slot_in   = tail.hit_idx;
               held_in   = tail.hit_bssid;
               action    = ACT_REMOVE;
               target    = tail.hit_idx;
            end else begin
               status_in = ST_MISSING;
               slot_in   = '0;
               held_in   = '0;
            end
         end
         default: begin
            // lookup, and the unused code behaves the same
            if (tail.hit) begin
               status_in = ST_FOUND;
               slot_in   = tail.hit_idx;
               held_in   = tail.hit_bssid;
            end else begin
               status_in = ST_MISSING;
               slot_in   = '0;
               held_in   = '0;
            end
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      head_in.active = 1'b0;
      op_in          = op_ff;
      mask_in        = mask_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_bssid_in   = rsp_bssid_ff;
      rsp_mask_in    = rsp_mask_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               head_in        = '0;
               head_in.active = 1'b1;
               head_in.phase  = PHASE_SEARCH;
               head_in.key    = req_station_address;
               head_in.bssid  = req_entry_bssid;
               head_in.mask   = ALL_ONES;
               op_in          = req_op;
               state_in       = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (tail.active) begin
               if (rebuild) begin
                  head_in        = '0;
                  head_in.active = 1'b1;
                  head_in.phase  = PHASE_APPLY;
                  head_in.key    = tail.key;
                  head_in.bssid  = tail.bssid;
                  head_in.action = action;
                  head_in.target = target;
                  head_in.mask   = ALL_ONES;
                  state_in       = S_APPLY;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_APPLY: begin
            if (tail.active) begin
               mask_in  = tail.mask;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = slot_ff[SLOT_OUT_W-1:0];
               rsp_bssid_in  = held_ff;
               rsp_mask_in   = mask_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_bssid_ff  <= rsp_bssid_in;
      rsp_mask_ff   <= rsp_mask_in;
      if (state_ff == S_SEARCH && tail.active) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         held_ff   <= held_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         mask_ff      <= ALL_ONES;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            hw_ff <= csr_write_data;
         end
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_stored_bssid = rsp_bssid_ff;
   assign rsp_mask_out     = rsp_mask_ff;

endmodule

// ===== design/vtb_cell.sv =====
// ---------------------------------------------------------------------------
// vtb_cell
// one table slot: holds an entry, searches it and folds it into the mask
// ---------------------------------------------------------------------------
module vtb_cell
   import vtb_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ADDR_W-1:0]   hw_address,
   input  vtb_link_type        left,
   output vtb_link_type        right
);

   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] bssid_ff, bssid_in;
   vtb_link_type      right_ff, right_in;
   logic              match;
   logic              own;

   assign match = valid_ff && (addr_ff == left.key);
   assign own   = (left.target == SLOT_W'(CELL_IDX));

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      bssid_in = bssid_ff;
      right_in = left;
      if (left.active) begin
         if (left.phase == PHASE_SEARCH) begin
            // lowest matching slot wins
            if (match && !left.hit) begin
               right_in.hit       = 1'b1;
               right_in.hit_idx   = SLOT_W'(CELL_IDX);
               right_in.hit_bssid = bssid_ff;
            end
            if (!valid_ff && !left.free_found) begin
               right_in.free_found = 1'b1;
               right_in.free_idx   = SLOT_W'(CELL_IDX);
            end
         end else begin
            if (own) begin
               case (left.action)
                  ACT_INSERT: begin
                     valid_in = 1'b1;
                     addr_in  = left.key;
                     bssid_in = left.bssid;
                  end
                  ACT_REMOVE: valid_in = 1'b0;
                  default: ;
               endcase
            end
            // mask over the slot as it stands after the update
            if (valid_in) begin
               right_in.mask = left.mask & ~(hw_address ^ bssid_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      bssid_ff <= bssid_in;
      if (reset) begin
         valid_ff <= 1'b0;
         right_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         right_ff <= right_in;
      end
   end

   assign right = right_ff;

endmodule

// ===== design/vtb_checker.sv =====
// ---------------------------------------------------------------------------
// vtb_checker
// port-level checks for the vap table, bound to the top level
// ---------------------------------------------------------------------------
`include "vap_table_with_bssid_mask_macros.svh"

module vtb_checker
   import vtb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_status,
   input logic [SLOT_OUT_W-1:0] rsp_slot_index,
   input logic [ADDR_W-1:0]     rsp_stored_bssid
);

   // a stalled response word holds
   `VTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index)
         && $stable(rsp_stored_bssid), "stalled response changed")

   // one request in flight: ready drops right after an accept
   `VTB_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready,
      !req_ready, "second request accepted while busy")

   // a full table reports no slot
   `VTB_ASSERT_NOW(a_full_no_slot, clock, reset, rsp_valid && rsp_status == ST_FULL,
      rsp_slot_index == '0 && rsp_stored_bssid == '0, "full response carries a slot")

   // a miss reports no slot
   `VTB_ASSERT_NOW(a_miss_no_slot, clock, reset, rsp_valid && rsp_status == ST_MISSING,
      rsp_slot_index == '0 && rsp_stored_bssid == '0, "miss response carries a slot")

endmodule

bind vap_table_with_bssid_mask vtb_checker u_vtb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_slot_index   (rsp_slot_index),
   .rsp_stored_bssid (rsp_stored_bssid)
);

// ===== dv/vap_table_with_bssid_mask_tb.sv =====
// ---------------------------------------------------------------------------
// vap_table_with_bssid_mask_tb
// drives add, remove and lookup words into the vap table under random idling
// and back-pressure, tracks its own copy of the slots and the bssid mask, and
// compares every response word field by field, in order
// ---------------------------------------------------------------------------
module vap_table_with_bssid_mask_tb;
   import vtb_pkg::*;

   typedef logic [ADDR_W-1:0] addr_type;

   // op code outside the documented set, decoded as a lookup
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int KEY_POOL     = 12;    // more keys than slots, so the table fills
   localparam int PHASE_ITEMS  = 400;
   localparam int PHASES       = 5;
   localparam int DRAIN_CYCLES = 40;    // lets the cells settle after the last response
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int STALL_LIMIT  = 3000;  // cycles with no word moving on either side

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_OUT_W-1:0] slot;
      addr_type              bssid;
      addr_type              mask;
   } vap_rsp_type;

   // -------------------------------------------------------------------------
   // predicted table contents and the queue of responses still owed
   // -------------------------------------------------------------------------
   class vap_table_tracker;
      bit          slot_used [MAX_ENTRIES_DEF];
      addr_type    slot_key  [MAX_ENTRIES_DEF];
      addr_type    slot_bssid[MAX_ENTRIES_DEF];
      addr_type    mask;
      addr_type    radio_address;
      vap_rsp_type pending_responses[$];
      int          errors;

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         mask          = ALL_ONES;
         radio_address = '0;
         errors        = 0;
      endfunction

      function void rebuild_mask();
         mask = ALL_ONES;
         foreach (slot_used[i]) begin
            if (slot_used[i]) mask &= ~(radio_address ^ slot_bssid[i]);
         end
      endfunction

      function void note_request(logic [1:0] op, addr_type key, addr_type bssid);
         vap_rsp_type r;
         int          hit;
         int          free_slot;
         hit       = -1;
         free_slot = -1;
         // walk downward so the lowest slot wins
         for (int i = MAX_ENTRIES_DEF - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_key[i] == key) hit = i;
            if (!slot_used[i]) free_slot = i;
         end
         r.status = ST_MISSING;
         r.slot   = '0;
         r.bssid  = '0;
         if (hit >= 0) begin
            r.slot  = hit[SLOT_OUT_W-1:0];
            r.bssid = slot_bssid[hit];
         end
         case (op)
            OP_ADD: begin
               if (hit >= 0) begin
                  r.status = ST_FOUND;
               end else if (free_slot < 0) begin
                  r.status = ST_FULL;
               end else begin
                  slot_used[free_slot]  = 1'b1;
                  slot_key[free_slot]   = key;
                  slot_bssid[free_slot] = bssid;
                  r.status = ST_OK;
                  r.slot   = free_slot[SLOT_OUT_W-1:0];
                  r.bssid  = bssid;
                  rebuild_mask();
               end
            end
            OP_REMOVE: begin
               if (hit >= 0) begin
                  r.status       = ST_OK;
                  slot_used[hit] = 1'b0;
               end
               // rebuilt even when nothing matched
               rebuild_mask();
            end
            default: begin
               if (hit >= 0) r.status = ST_FOUND;
            end
         endcase
         r.mask = mask;
         pending_responses.push_back(r);
      endfunction

      function void check_response(logic [1:0] status, logic [SLOT_OUT_W-1:0] slot,
                                   addr_type bssid, addr_type mask_seen);
         vap_rsp_type want;
         if (pending_responses.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
            return;
         end
         want = pending_responses.pop_front();
         if (status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status);
            errors++;
         end
         if (slot !== want.slot) begin
            $error("slot_index expected %0d actual %0d", want.slot, slot);
            errors++;
         end
         if (bssid !== want.bssid) begin
            $error("stored_bssid expected %h actual %h", want.bssid, bssid);
            errors++;
         end
         if (mask_seen !== want.mask) begin
            $error("mask_out expected %h actual %h", want.mask, mask_seen);
            errors++;
         end
      endfunction

      function int pending();
         return pending_responses.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block ports; the driven inputs all known from time zero
   // -------------------------------------------------------------------------
   logic                  clock               = 1'b0;
   logic                  reset               = 1'b1;
   logic                  req_valid           = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_op              = OP_LOOKUP;
   addr_type              req_station_address = '0;
   addr_type              req_entry_bssid     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready           = 1'b0;
   logic [1:0]            rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot_index;
   addr_type              rsp_stored_bssid;
   addr_type              rsp_mask_out;
   logic                  csr_write_enable    = 1'b0;
   addr_type              csr_write_data      = '0;

   vap_table_tracker board;
   addr_type         key_pool[KEY_POOL];

   // phase controls shared between the sender and the receiver
   bit steady       = 1'b0;   // no idling on either side
   bit hold_pending = 1'b0;   // receiver takes one long hold-off

   always #5 clock = ~clock;

   vap_table_with_bssid_mask DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_station_address (req_station_address),
      .req_entry_bssid     (req_entry_bssid),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_stored_bssid    (rsp_stored_bssid),
      .rsp_mask_out        (rsp_mask_out),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   function automatic addr_type rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ADDR_W-1:0];
   endfunction

   // -------------------------------------------------------------------------
   // request side: optional gap, then hold the word until it is taken
   // called at a rising edge; leaves req_valid high after acceptance
   // -------------------------------------------------------------------------
   task automatic send_request(logic [1:0] op, addr_type key, addr_type bssid);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_station_address <= key;
      req_entry_bssid     <= bssid;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.note_request(op, key, bssid);
   endtask

   // hw_address write, only while the table is idle
   task automatic write_radio_address(addr_type value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.radio_address = value;
   endtask

   // stop offering, let every owed response come back, then let the cells settle
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // directed part: miss on empty table, fill, duplicate, full, op 3,
   // removes hit and miss, reuse of a freed slot, then empty it again
   // -------------------------------------------------------------------------
   task automatic run_directed();
      addr_type keys[MAX_ENTRIES_DEF];
      addr_type spare_key;
      addr_type hw;
      hw = board.radio_address;
      keys[0] = '0;
      keys[1] = ALL_ONES;
      for (int i = 2; i < MAX_ENTRIES_DEF; i++) keys[i] = rand48();
      spare_key = rand48();

      // empty table: lookup shows the reset mask, remove miss still rebuilds
      send_request(OP_LOOKUP, keys[0], ALL_ONES);
      send_request(OP_REMOVE, keys[0], '0);

      // fill every slot, bssid extremes first, then near the radio address
      send_request(OP_ADD, keys[0], ALL_ONES);
      send_request(OP_ADD, keys[1], '0);
      for (int i = 2; i < MAX_ENTRIES_DEF; i++) begin
         send_request(OP_ADD, keys[i], hw ^ (addr_type'(1) << (i * 7)));
      end

      // duplicate keeps the old bssid, new key finds the table full
      send_request(OP_ADD, keys[1], rand48());
      send_request(OP_ADD, spare_key, hw);

      send_request(OP_LOOKUP, keys[0], '0);
      send_request(OP_UNUSED, keys[1], ALL_ONES);
      send_request(OP_LOOKUP, spare_key, '0);
      send_request(OP_REMOVE, spare_key, '0);

      // free slot zero and take it again with the spare key
      send_request(OP_REMOVE, keys[0], '0);
      send_request(OP_ADD, spare_key, hw);

      for (int i = 1; i < MAX_ENTRIES_DEF; i++) send_request(OP_REMOVE, keys[i], '0);
      send_request(OP_REMOVE, spare_key, '0);
   endtask

   // -------------------------------------------------------------------------
   // random part: keys mostly from a small pool so adds, hits, removes and a
   // full table all recur; bssids often near the radio address so the mask
   // keeps some ones; stray keys only on remove, lookup and the unused op
   // code 3
   task automatic run_random(int count);
      logic [1:0] op;
      addr_type   key;
      addr_type   bssid;
      addr_type   hw;
      int         pick;
      for (int n = 0; n < count; n++) begin
         hw   = board.radio_address;
         pick = $urandom_range(0, 99);
         if (pick < 40)      op = OP_ADD;
         else if (pick < 70) op = OP_REMOVE;
         else if (pick < 95) op = OP_LOOKUP;
         else                op = OP_UNUSED;
         if (op != OP_ADD && $urandom_range(0, 9) == 0) key = rand48();
         else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
         case ($urandom_range(0, 3))
            0:       bssid = rand48();
            1:       bssid = hw ^ (addr_type'(1) << $urandom_range(0, ADDR_W - 1));
            2:       bssid = hw ^ (rand48() & rand48() & rand48());
            default: bssid = hw;
         endcase
         send_request(op, key, bssid);
      end
   endtask

   // -------------------------------------------------------------------------
   // response side: random stall per word, one long hold-off on request
   // -------------------------------------------------------------------------
   initial begin : response_side
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall        = HOLD_CYCLES;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 7);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         board.check_response(rsp_status, rsp_slot_index, rsp_stored_bssid, rsp_mask_out);
      end
   end

   // -------------------------------------------------------------------------
   // watchdog: too long with no word moving means the block is stuck
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      addr_type radio_settings[PHASES];
      board = new();
      foreach (key_pool[i]) key_pool[i] = rand48();

      // one hw_address per random phase, extremes included
      radio_settings[0] = ALL_ONES;
      radio_settings[1] = '0;
      radio_settings[2] = rand48();
      radio_settings[3] = 48'hAAAA_5555_F0F0;
      radio_settings[4] = rand48();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_radio_address(rand48());
      run_directed();
      wait_until_idle();

      for (int p = 0; p < PHASES; p++) begin
         write_radio_address(radio_settings[p]);
         // phase 1 fills the block behind a stalled receiver
         if (p == 1) hold_pending = 1'b1;
         // phase 3 runs back to back on both sides
         steady = (p == 3);
         run_random(PHASE_ITEMS);
         wait_until_idle();
         steady = 1'b0;
      end

      if (board.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
